FILE: sv/dfrs_pkg.sv
package dfrs_pkg;

   // Event codes carried in the operation field.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_FLUSH = 2'd1;
   localparam logic [1:0] OP_DONE  = 2'd2;

   // Device command codes.
   localparam logic [2:0] CMD_TRANSFER = 3'd0;
   localparam logic [2:0] CMD_RFLUSH   = 3'd1;
   localparam logic [2:0] CMD_DINFO    = 3'd2;
   localparam logic [2:0] CMD_CREATE   = 3'd3;
   localparam logic [2:0] CMD_ATTACH   = 3'd4;
   localparam logic [2:0] CMD_SCANOUT  = 3'd5;

   // Response header types.
   localparam logic [31:0] RESP_OK_NODATA       = 32'h0000_1100;
   localparam logic [31:0] RESP_OK_DISPLAY_INFO = 32'h0000_1101;

   // Configuration register indexes.
   localparam logic [1:0] CSR_RESIZE_PERIOD  = 2'd0;
   localparam logic [1:0] CSR_INITIAL_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_INITIAL_HEIGHT = 2'd2;
   localparam logic [1:0] CSR_INITIAL_ADDR   = 2'd3;

   // Reset values.
   localparam logic [9:0]  RESET_PERIOD    = 10'd50;
   localparam logic [15:0] RESET_WIDTH     = 16'd1280;
   localparam logic [15:0] RESET_HEIGHT    = 16'd800;
   localparam logic [31:0] RESET_ACTIVE_ID = 32'd1;
   localparam logic [31:0] RESET_NEXT_ID   = 32'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] response_type;
      logic        display_found;
      logic [15:0] display_width;
      logic [15:0] display_height;
      logic        backing_ok;
      logic [47:0] backing_addr_in;
   } req_type;

   typedef struct packed {
      logic        issue;
      logic [2:0]  command;
      logic [31:0] rsrc_id;
      logic [15:0] rect_width;
      logic [15:0] rect_height;
      logic [47:0] backing_addr;
      logic [31:0] backing_bytes;
      logic        framebuffer_changed;
      logic        ready_res;
      logic        fault;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  index;
      logic [47:0] wdata;
   } csr_write_type;

endpackage

FILE: sv/dfrs_core.sv
module dfrs_core (
   input  logic                   clock,
   input  logic                   reset,
   input  dfrs_pkg::csr_write_type csr,
   input  logic                   step_en,
   input  dfrs_pkg::req_type      req,
   output dfrs_pkg::rsp_type      rsp
);

   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_TRANSFER = 3'd1;
   localparam logic [2:0] PH_RFLUSH   = 3'd2;
   localparam logic [2:0] PH_DINFO    = 3'd3;
   localparam logic [2:0] PH_CREATE   = 3'd4;
   localparam logic [2:0] PH_ATTACH   = 3'd5;
   localparam logic [2:0] PH_SCANOUT  = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic        dirty_ff, dirty_in;
   logic        oper_ff, oper_in;
   logic [9:0]  tick_count_ff, tick_count_in;
   logic [9:0]  period_ff;
   logic [31:0] active_id_ff, active_id_in;
   logic [31:0] next_id_ff, next_id_in;
   logic [15:0] cur_width_ff, cur_width_in;
   logic [15:0] cur_height_ff, cur_height_in;
   logic [31:0] pend_id_ff, pend_id_in;
   logic [47:0] pend_addr_ff, pend_addr_in;
   logic [31:0] pend_size_ff, pend_size_in;
   logic [15:0] pend_width_ff, pend_width_in;
   logic [15:0] pend_height_ff, pend_height_in;

   logic [31:0] area;
   logic        resize_ok;
   logic [9:0]  tick_next;
   logic [31:0] expected;
   logic        do_transfer;

   // Pixel count of the reported mode; the byte size is four times that and
   // must still fit in 32 bits.
   assign area = 32'(req.display_width) * 32'(req.display_height);
   assign resize_ok = req.display_found && req.backing_ok
                      && ((req.display_width != cur_width_ff)
                          || (req.display_height != cur_height_ff))
                      && (req.display_width != 16'd0) && (req.display_height != 16'd0)
                      && (area[31:30] == 2'b00);
   assign tick_next = tick_count_ff + 10'd1;
   assign expected = (phase_ff == PH_DINFO) ? dfrs_pkg::RESP_OK_DISPLAY_INFO
                                            : dfrs_pkg::RESP_OK_NODATA;

   always_comb begin
      phase_in       = phase_ff;
      dirty_in       = dirty_ff;
      oper_in        = oper_ff;
      tick_count_in  = tick_count_ff;
      active_id_in   = active_id_ff;
      next_id_in     = next_id_ff;
      cur_width_in   = cur_width_ff;
      cur_height_in  = cur_height_ff;
      pend_id_in     = pend_id_ff;
      pend_addr_in   = pend_addr_ff;
      pend_size_in   = pend_size_ff;
      pend_width_in  = pend_width_ff;
      pend_height_in = pend_height_ff;
      rsp            = '0;
      do_transfer    = 1'b0;

      if (oper_ff) begin
         case (req.operation)
            dfrs_pkg::OP_TICK, dfrs_pkg::OP_FLUSH: begin
               if (req.operation == dfrs_pkg::OP_FLUSH) begin
                  dirty_in = 1'b1;
               end
               if (phase_ff == PH_IDLE) begin
                  if (dirty_in) begin
                     do_transfer = 1'b1;
                  end else if (tick_next >= period_ff) begin
                     tick_count_in = 10'd0;
                     phase_in      = PH_DINFO;
                     rsp.issue     = 1'b1;
                     rsp.command   = dfrs_pkg::CMD_DINFO;
                  end else begin
                     tick_count_in = tick_next;
                  end
               end
            end
            dfrs_pkg::OP_DONE: begin
               if (phase_ff != PH_IDLE) begin
                  phase_in = PH_IDLE;
                  if (req.response_type != expected) begin
                     oper_in   = 1'b0;
                     rsp.fault = 1'b1;
                  end else begin
                     case (phase_ff)
                        PH_TRANSFER: begin
                           phase_in        = PH_RFLUSH;
                           rsp.issue       = 1'b1;
                           rsp.command     = dfrs_pkg::CMD_RFLUSH;
                           rsp.rsrc_id     = active_id_ff;
                           rsp.rect_width  = cur_width_ff;
                           rsp.rect_height = cur_height_ff;
                        end
                        PH_DINFO: begin
                           if (resize_ok) begin
                              pend_id_in      = next_id_ff;
                              next_id_in      = next_id_ff + 32'd1;
                              pend_addr_in    = req.backing_addr_in;
                              pend_size_in    = {area[29:0], 2'b00};
                              pend_width_in   = req.display_width;
                              pend_height_in  = req.display_height;
                              phase_in        = PH_CREATE;
                              rsp.issue       = 1'b1;
                              rsp.command     = dfrs_pkg::CMD_CREATE;
                              rsp.rsrc_id     = next_id_ff;
                              rsp.rect_width  = req.display_width;
                              rsp.rect_height = req.display_height;
                           end
                        end
                        PH_CREATE: begin
                           phase_in          = PH_ATTACH;
                           rsp.issue         = 1'b1;
                           rsp.command       = dfrs_pkg::CMD_ATTACH;
                           rsp.rsrc_id       = pend_id_ff;
                           rsp.backing_addr  = pend_addr_ff;
                           rsp.backing_bytes = pend_size_ff;
                        end
                        PH_ATTACH: begin
                           phase_in        = PH_SCANOUT;
                           rsp.issue       = 1'b1;
                           rsp.command     = dfrs_pkg::CMD_SCANOUT;
                           rsp.rsrc_id     = pend_id_ff;
                           rsp.rect_width  = pend_width_ff;
                           rsp.rect_height = pend_height_ff;
                        end
                        PH_SCANOUT: begin
                           // Install the new framebuffer, then refresh it.
                           cur_width_in            = pend_width_ff;
                           cur_height_in           = pend_height_ff;
                           active_id_in            = pend_id_ff;
                           do_transfer             = 1'b1;
                           rsp.backing_addr        = pend_addr_ff;
                           rsp.backing_bytes       = pend_size_ff;
                           rsp.framebuffer_changed = 1'b1;
                        end
                        default: begin
                           // Resource flush done: pick up a flush that came in
                           // while the device was busy.
                           do_transfer = dirty_ff;
                        end
                     endcase
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (do_transfer) begin
         dirty_in        = 1'b0;
         phase_in        = PH_TRANSFER;
         rsp.issue       = 1'b1;
         rsp.command     = dfrs_pkg::CMD_TRANSFER;
         rsp.rsrc_id     = active_id_in;
         rsp.rect_width  = cur_width_in;
         rsp.rect_height = cur_height_in;
      end

      rsp.ready_res = oper_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         dirty_ff       <= 1'b0;
         oper_ff        <= 1'b1;
         tick_count_ff  <= 10'd0;
         period_ff      <= dfrs_pkg::RESET_PERIOD;
         active_id_ff   <= dfrs_pkg::RESET_ACTIVE_ID;
         next_id_ff     <= dfrs_pkg::RESET_NEXT_ID;
         cur_width_ff   <= dfrs_pkg::RESET_WIDTH;
         cur_height_ff  <= dfrs_pkg::RESET_HEIGHT;
         pend_id_ff     <= 32'd0;
         pend_addr_ff   <= 48'd0;
         pend_size_ff   <= 32'd0;
         pend_width_ff  <= 16'd0;
         pend_height_ff <= 16'd0;
      end else begin
         if (step_en) begin
            phase_ff       <= phase_in;
            dirty_ff       <= dirty_in;
            oper_ff        <= oper_in;
            tick_count_ff  <= tick_count_in;
            active_id_ff   <= active_id_in;
            next_id_ff     <= next_id_in;
            cur_width_ff   <= cur_width_in;
            cur_height_ff  <= cur_height_in;
            pend_id_ff     <= pend_id_in;
            pend_addr_ff   <= pend_addr_in;
            pend_size_ff   <= pend_size_in;
            pend_width_ff  <= pend_width_in;
            pend_height_ff <= pend_height_in;
         end
         // The installed framebuffer address is never read back on its own,
         // so a write of the initial address has no visible effect.
         if (csr.valid) begin
            case (csr.index)
               dfrs_pkg::CSR_RESIZE_PERIOD:  period_ff     <= csr.wdata[9:0];
               dfrs_pkg::CSR_INITIAL_WIDTH:  cur_width_ff  <= csr.wdata[15:0];
               dfrs_pkg::CSR_INITIAL_HEIGHT: cur_height_ff <= csr.wdata[15:0];
               default: begin
               end
            endcase
         end
      end
   end

endmodule

FILE: sv/display_flush_resize_sequencer_top.sv
// Display flush and resize sequencer.
// Events enter on the req_ channel as one word each: a poll tick, a flush
// request or a command completion with its response type and display mode.
// Every accepted word produces exactly one word on the rsp_ channel, which
// says whether a device command is issued and with which arguments.
// Configuration (resize period, initial framebuffer geometry) is written on
// the csr_ channel, which is always ready; the user must make writes only
// while the sequencer has no word in flight, as the block does not enforce it.
// A word accepted into the input register is evaluated there and, once the
// result register is empty or being drained, lands in the result register,
// which drives rsp_valid. Throughput is one word per cycle while rsp_ready
// stays high; the sequencer state is updated in the same cycle that the
// result register is loaded, so the next word sees it at once.
// When the receiver holds rsp_ready low, the result register holds its word
// and the input register takes one more word; after that req_ready drops.
// Reset clears both registers, puts the sequencer idle and operational with
// resource 1 active and a 1280 by 800 framebuffer, and a resize period of 50.
module display_flush_resize_sequencer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dfrs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dfrs_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [47:0]       csr_wdata
);

   logic                   in_valid_ff;
   dfrs_pkg::req_type      in_data_ff;
   logic                   out_valid_ff;
   dfrs_pkg::rsp_type      out_data_ff;
   logic                   advance;
   dfrs_pkg::rsp_type      step_rsp;
   dfrs_pkg::csr_write_type csr;

   // A held word moves into the result register whenever that register is
   // empty or being drained in this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign csr_ready = 1'b1;

   assign csr.valid = csr_valid;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   dfrs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr),
      .step_en (advance),
      .req     (in_data_ff),
      .rsp     (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

endmodule
